/* sv/qstc_pkg.sv */
// Shared constants and types of the smallest-three quaternion codec.
`timescale 1ns / 1ps
`default_nettype none

package qstc_pkg;

    localparam int NUM_STAGES  = 15;
    localparam int SQRT_STAGES = 8;
    localparam int SQRT_FIRST  = 6;
    localparam int COMP_W      = 16;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 2;
    localparam int NUM_COMP    = 4;
    localparam int DATA_W      = 96;

    localparam logic [COMP_W-1:0] HALF_RANGE = 16'd23170;
    localparam logic [31:0]       INV_RANGE  = 32'd3036999560;
    localparam logic [31:0]       RANGE_Q31  = 32'd3037001440;

    localparam logic CMD_COMPRESS   = 1'b0;
    localparam logic CMD_DECOMPRESS = 1'b1;

    typedef logic [COMP_W-1:0] t_comp;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] r;
    } t_sqrt_state;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_comp [2:0]      c;
    } t_dec_side;

endpackage

`default_nettype wire

/* sv/quaternion_smallest_three_codec.sv */
// Top level of the smallest-three quaternion codec (compress and decompress).
// Throughput is one beat per cycle while the output is not stalled; the square root runs as eight pipelined stages.
// A stalled output lets the stages fill their bubbles and holds the pipeline only once it is full.
// Synchronous active-low reset clears the stage valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_smallest_three_codec #(
    parameter int FIELD_BITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // comp_x, comp_y, comp_z, comp_w, packed_word
    input  wire logic [qstc_pkg::DATA_W-1:0]   s_axis_tdata,
    // command
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // packed_result, out_x, out_y, out_z, out_w
    output logic [qstc_pkg::DATA_W-1:0]        m_axis_tdata
);
    import qstc_pkg::*;

    logic [NUM_STAGES-1:0]             en;
    logic [NUM_STAGES-1:0]             r_cmd;
    logic [NUM_COMP-1:0][COMP_W-1:0]   comp_in;
    logic [NUM_COMP-1:0][COMP_W-1:0]   comp_out;
    logic [WORD_W-1:0]                 word_out;
    logic                              is_dec;

    qstc_flow u_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_en    (en)
    );

    assign comp_in = s_axis_tdata[NUM_COMP*COMP_W-1:0];

    qstc_compress #(
        .FIELD_BITS (FIELD_BITS)
    ) u_compress (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_comp (comp_in),
        .o_word (word_out)
    );

    qstc_decompress #(
        .FIELD_BITS (FIELD_BITS)
    ) u_decompress (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_word (s_axis_tdata[DATA_W-1 -: WORD_W]),
        .o_comp (comp_out)
    );

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cmd[0] <= s_axis_tuser[0];
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    assign is_dec = (r_cmd[NUM_STAGES-1] == CMD_DECOMPRESS);

    assign m_axis_tdata = {is_dec ? comp_out : '0, is_dec ? '0 : word_out};

endmodule

`default_nettype wire

/* sv/qstc_flow.sv */
// Valid bits and per-stage load enables of the codec pipeline.
`timescale 1ns / 1ps
`default_nettype none

module qstc_flow (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [qstc_pkg::NUM_STAGES-1:0]     o_en
);
    import qstc_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            o_en[k] = i_ready || (((~r_vld) >> k) != '0);
        end
        n_vld[0] = o_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = o_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = o_en[0];
    assign o_valid = r_vld[NUM_STAGES-1];

endmodule

`default_nettype wire

/* sv/qstc_compress.sv */
// Compress datapath: largest-magnitude search, quantizers and packing.
`timescale 1ns / 1ps
`default_nettype none

module qstc_compress #(
    parameter int FIELD_BITS = 10
) (
    input  wire logic                                       i_clk,
    input  wire logic [qstc_pkg::NUM_STAGES-1:0]            i_en,
    input  wire logic [qstc_pkg::NUM_COMP-1:0][qstc_pkg::COMP_W-1:0] i_comp,
    output logic [qstc_pkg::WORD_W-1:0]                     o_word
);
    import qstc_pkg::*;

    localparam int F   = FIELD_BITS;
    localparam int M   = (1 << FIELD_BITS) - 1;
    localparam int TMW = COMP_W + FIELD_BITS;
    localparam int PW  = TMW + 32;
    localparam int QW  = PW + 1 - 47;
    localparam int DLY = NUM_STAGES - 5;

    logic [3:0][16:0]     r_c1_val, n_c1_val;
    logic [3:0][16:0]     r_c1_abs, n_c1_abs;
    logic [2:0][17:0]     r_c2_t, n_c2_t;
    logic [IDX_W-1:0]     r_c2_idx, n_c2_idx;
    logic [2:0][TMW-1:0]  r_c3_tm, n_c3_tm;
    logic [IDX_W-1:0]     r_c3_idx;
    logic [2:0][PW-1:0]   r_c4_p, n_c4_p;
    logic [IDX_W-1:0]     r_c4_idx;
    logic [WORD_W-1:0]    r_c5_word, n_c5_word;
    logic [WORD_W-1:0]    r_dly [DLY];

    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            n_c1_val[i] = {i_comp[i][COMP_W-1], i_comp[i]};
            n_c1_abs[i] = i_comp[i][COMP_W-1] ? (17'd0 - n_c1_val[i]) : n_c1_val[i];
        end
    end

    always_comb begin
        logic [16:0]      best;
        logic             neg;
        logic [IDX_W-1:0] sel;
        logic [16:0]      v;
        best     = '0;
        n_c2_idx = '0;
        neg      = 1'b0;
        for (int i = 0; i < NUM_COMP; i++) begin
            if (r_c1_abs[i] > best) begin
                best     = r_c1_abs[i];
                n_c2_idx = IDX_W'(i);
                neg      = r_c1_val[i][16];
            end
        end
        for (int j = 0; j < 3; j++) begin
            sel       = (IDX_W'(j) < n_c2_idx) ? IDX_W'(j) : IDX_W'(j + 1);
            v         = neg ? (17'd0 - r_c1_val[sel]) : r_c1_val[sel];
            n_c2_t[j] = {v[16], v} + 18'(HALF_RANGE);
        end
    end

    always_comb begin
        logic [COMP_W-1:0] tc;
        for (int j = 0; j < 3; j++) begin
            tc         = r_c2_t[j][17] ? '0 : r_c2_t[j][COMP_W-1:0];
            n_c3_tm[j] = TMW'(tc) * TMW'(M);
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_c4_p[j] = PW'(r_c3_tm[j]) * PW'(INV_RANGE);
        end
    end

    always_comb begin
        logic [PW:0]   sum;
        logic [QW-1:0] q;
        n_c5_word = '0;
        n_c5_word[WORD_W-1 -: IDX_W] = r_c4_idx;
        for (int j = 0; j < 3; j++) begin
            sum = (PW + 1)'(r_c4_p[j]) + ((PW + 1)'(1) << 46);
            q   = sum[PW:47];
            n_c5_word[j*F +: F] = (q > QW'(M)) ? F'(M) : q[F-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c1_val <= n_c1_val;
            r_c1_abs <= n_c1_abs;
        end
        if (i_en[1]) begin
            r_c2_t   <= n_c2_t;
            r_c2_idx <= n_c2_idx;
        end
        if (i_en[2]) begin
            r_c3_tm  <= n_c3_tm;
            r_c3_idx <= r_c2_idx;
        end
        if (i_en[3]) begin
            r_c4_p   <= n_c4_p;
            r_c4_idx <= r_c3_idx;
        end
        if (i_en[4]) begin
            r_c5_word <= n_c5_word;
        end
        if (i_en[5]) begin
            r_dly[0] <= r_c5_word;
        end
        for (int k = 1; k < DLY; k++) begin
            if (i_en[5 + k]) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_word = r_dly[DLY-1];

endmodule

`default_nettype wire

/* sv/qstc_sqrt_stage.sv */
// One pipeline stage of the rounded square root, two result bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module qstc_sqrt_stage #(
    parameter int STEP = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire qstc_pkg::t_sqrt_state i_state,
    input  wire qstc_pkg::t_dec_side   i_side,
    output qstc_pkg::t_sqrt_state      o_state,
    output qstc_pkg::t_dec_side        o_side
);
    import qstc_pkg::*;

    localparam int BIT_HI = 30 - 4 * STEP;

    t_sqrt_state r_state, n_state;
    t_dec_side   r_side;

    always_comb begin
        logic [31:0] x;
        logic [31:0] r;
        logic [31:0] b;
        logic [31:0] trial;
        x = i_state.x;
        r = i_state.r;
        for (int k = 0; k < 2; k++) begin
            b     = 32'd1 << (BIT_HI - 2 * k);
            trial = r + b;
            if (x >= trial) begin
                x = x - trial;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        n_state.x = x;
        n_state.r = r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_side  <= i_side;
        end
    end

    assign o_state = r_state;
    assign o_side  = r_side;

endmodule

`default_nettype wire

/* sv/qstc_decompress.sv */
// Decompress datapath: dequantizers, radicand and pipelined square root.
`timescale 1ns / 1ps
`default_nettype none

module qstc_decompress #(
    parameter int FIELD_BITS = 10
) (
    input  wire logic                                        i_clk,
    input  wire logic [qstc_pkg::NUM_STAGES-1:0]             i_en,
    input  wire logic [qstc_pkg::WORD_W-1:0]                 i_word,
    output logic [qstc_pkg::NUM_COMP-1:0][qstc_pkg::COMP_W-1:0] o_comp
);
    import qstc_pkg::*;

    localparam int F   = FIELD_BITS;
    localparam int M   = (1 << FIELD_BITS) - 1;
    localparam int AW  = FIELD_BITS + 33;
    localparam int XW  = AW - 16;
    localparam int RW  = XW - FIELD_BITS + 2;
    localparam int PW2 = XW + RW;
    localparam int MW  = RW + FIELD_BITS;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << XW) / M);

    logic [2:0][XW-1:0]   r_d1_x, n_d1_x;
    logic [IDX_W-1:0]     r_d1_idx;
    logic [2:0][PW2-1:0]  r_d2_p, n_d2_p;
    logic [2:0][XW-1:0]   r_d2_x;
    logic [IDX_W-1:0]     r_d2_idx;
    logic [2:0][RW-1:0]   r_d3_q0, n_d3_q0;
    logic [2:0][MW-1:0]   r_d3_qm, n_d3_qm;
    logic [2:0][XW-1:0]   r_d3_x;
    logic [IDX_W-1:0]     r_d3_idx;
    t_comp [2:0]          r_d4_c, n_d4_c;
    logic [IDX_W-1:0]     r_d4_idx;
    logic [2:0][30:0]     r_d5_sq, n_d5_sq;
    t_comp [2:0]          r_d5_c;
    logic [IDX_W-1:0]     r_d5_idx;
    t_sqrt_state          r_d6_state, n_d6_state;
    t_dec_side            r_d6_side;
    t_sqrt_state          sq_state [SQRT_STAGES+1];
    t_dec_side            sq_side  [SQRT_STAGES+1];
    logic [NUM_COMP-1:0][COMP_W-1:0] r_out, n_out;

    always_comb begin
        logic [AW-1:0] a;
        for (int j = 0; j < 3; j++) begin
            a = AW'(i_word[j*F +: F]) * AW'(RANGE_Q31) + (AW'(M) << 15);
            n_d1_x[j] = a[AW-1:16];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d2_p[j] = PW2'(r_d1_x[j]) * PW2'(RECIP);
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d3_q0[j] = r_d2_p[j][PW2-1:XW];
            n_d3_qm[j] = MW'(n_d3_q0[j]) * MW'(M);
        end
    end

    always_comb begin
        logic [MW-1:0] rem;
        logic [RW-1:0] q;
        for (int j = 0; j < 3; j++) begin
            rem       = MW'(r_d3_x[j]) - r_d3_qm[j];
            q         = r_d3_q0[j] + ((rem >= MW'(M)) ? RW'(1) : RW'(0));
            n_d4_c[j] = COMP_W'(q - RW'(HALF_RANGE));
        end
    end

    always_comb begin
        logic signed [31:0] sq;
        for (int j = 0; j < 3; j++) begin
            sq         = 32'($signed(r_d4_c[j])) * 32'($signed(r_d4_c[j]));
            n_d5_sq[j] = sq[30:0];
        end
    end

    always_comb begin
        logic [31:0] sum;
        logic [32:0] rad;
        sum = 32'(r_d5_sq[0]) + 32'(r_d5_sq[1]) + 32'(r_d5_sq[2]);
        rad = (33'd1 << 30) - 33'(sum);
        n_d6_state.x = rad[32] ? '0 : rad[31:0];
        n_d6_state.r = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d1_x   <= n_d1_x;
            r_d1_idx <= i_word[WORD_W-1 -: IDX_W];
        end
        if (i_en[1]) begin
            r_d2_p   <= n_d2_p;
            r_d2_x   <= r_d1_x;
            r_d2_idx <= r_d1_idx;
        end
        if (i_en[2]) begin
            r_d3_q0  <= n_d3_q0;
            r_d3_qm  <= n_d3_qm;
            r_d3_x   <= r_d2_x;
            r_d3_idx <= r_d2_idx;
        end
        if (i_en[3]) begin
            r_d4_c   <= n_d4_c;
            r_d4_idx <= r_d3_idx;
        end
        if (i_en[4]) begin
            r_d5_sq  <= n_d5_sq;
            r_d5_c   <= r_d4_c;
            r_d5_idx <= r_d4_idx;
        end
        if (i_en[5]) begin
            r_d6_state    <= n_d6_state;
            r_d6_side.idx <= r_d5_idx;
            r_d6_side.c   <= r_d5_c;
        end
    end

    assign sq_state[0] = r_d6_state;
    assign sq_side[0]  = r_d6_side;

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
        qstc_sqrt_stage #(
            .STEP (s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_en    (i_en[SQRT_FIRST + s]),
            .i_state (sq_state[s]),
            .i_side  (sq_side[s]),
            .o_state (sq_state[s+1]),
            .o_side  (sq_side[s+1])
        );
    end

    always_comb begin
        t_sqrt_state      st;
        t_dec_side        sd;
        logic [31:0]      root;
        logic [COMP_W-1:0] sat;
        logic [IDX_W-1:0] sel;
        st   = sq_state[SQRT_STAGES];
        sd   = sq_side[SQRT_STAGES];
        root = st.r + ((st.x > st.r) ? 32'd1 : 32'd0);
        sat  = (root > 32'd32767) ? 16'h7FFF : root[COMP_W-1:0];
        for (int p = 0; p < NUM_COMP; p++) begin
            sel = (IDX_W'(p) < sd.idx) ? IDX_W'(p) : IDX_W'(p - 1);
            n_out[p] = (IDX_W'(p) == sd.idx) ? sat : sd.c[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    assign o_comp = r_out;

endmodule

`default_nettype wire

/* sv/qstc_checker.sv */
// Port-level assertions for the codec top level and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module qstc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [qstc_pkg::DATA_W-1:0] m_axis_tdata
);
    import qstc_pkg::*;

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output beat changed while stalled.");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input stalled without a stalled output.");

    a_one_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[WORD_W-1:0] == '0) ||
                          (m_axis_tdata[DATA_W-1:WORD_W] == '0))
        else $error("Output carries both a packed word and components.");

endmodule

bind quaternion_smallest_three_codec qstc_checker u_qstc_checker (.*);

`default_nettype wire
